// ----- design/nmea_sentence_checker_top_defines.svh -----
// ----------------------------------------------------------------------------
// NMEA sentence checker assertion macros
// Shared property forms for the checker's concurrent assertions.
// ----------------------------------------------------------------------------
`ifndef NMEA_SENTENCE_CHECKER_TOP_DEFINES_SVH
`define NMEA_SENTENCE_CHECKER_TOP_DEFINES_SVH

// same-cycle implication, disabled during reset
`define NSC_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("nsc assertion failed");

// next-cycle implication, disabled during reset
`define NSC_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("nsc assertion failed");

`endif

// ----- design/nsc_pkg.sv -----
// ----------------------------------------------------------------------------
// NMEA sentence checker package
// Character codes, status codes, result type and hex digit decode.
// ----------------------------------------------------------------------------
package nsc_pkg;

  localparam int MaxSentenceDefault = 128;

  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_G      = 8'h47;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_LF     = 8'h0A;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_BAD_START = 2'd1,
    ST_BAD_END  = 2'd2,
    ST_BAD_SUM  = 2'd3
  } status_t;

  // packed so that status sits in the low bits, as on tdata
  typedef struct packed {
    logic [7:0] sentence_length;
    logic [7:0] field_total;
    logic [7:0] received_sum;
    logic [7:0] computed_sum;
    status_t    status;
  } result_t;

  localparam int ResultWidth = $bits(result_t);
  localparam int TdataWidth  = ((ResultWidth + 7) / 8) * 8;

  // invalid digits decode as zero
  function automatic logic [3:0] hex_value(input logic [7:0] c);
    logic [3:0] v;
    v = 4'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      v = c[3:0];
    end else if ((c >= 8'h41 && c <= 8'h46) || (c >= 8'h61 && c <= 8'h66)) begin
      v = 4'(c[2:0] + 3'd1) + 4'd8;
    end
    return v;
  endfunction

endpackage

// ----- design/nsc_tracker.sv -----
// ----------------------------------------------------------------------------
// NMEA sentence tracker
// Per-byte sentence state update and end-of-sentence result build.
// ----------------------------------------------------------------------------
module nsc_tracker import nsc_pkg::*; #(
  parameter int MAX_SENTENCE = MaxSentenceDefault
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       byte_valid,
  input  logic [7:0] data_byte,
  output logic       res_valid,
  output result_t    res
);

  localparam logic [7:0] MaxLen = 8'(MAX_SENTENCE);

  logic       in_sentence;
  logic [7:0] byte_position;
  logic [7:0] running_xor;
  logic       star_seen;
  logic       second_is_g;
  logic [7:0] field_counter;
  logic       overflowed;
  logic [7:0] recent_bytes [3];

  logic       is_dollar;
  logic       is_lf;
  logic       active;
  logic [7:0] pos_next;
  logic       ovf_next;
  logic [7:0] rx_sum;

  assign is_dollar = (data_byte == CH_DOLLAR);
  assign is_lf     = (data_byte == CH_LF);
  assign active    = byte_valid && !is_dollar && in_sentence;

  // length saturates at the limit; any byte past it marks overflow
  assign pos_next = (byte_position < MaxLen) ? byte_position + 8'd1 : byte_position;
  assign ovf_next = overflowed || (byte_position >= MaxLen);
  assign rx_sum   = {hex_value(recent_bytes[2]), hex_value(recent_bytes[1])};

  always_comb begin
    res.computed_sum    = running_xor;
    res.received_sum    = rx_sum;
    res.field_total     = field_counter;
    res.sentence_length = pos_next;
    priority if (!second_is_g) begin
      res.status = ST_BAD_START;
    end else if (recent_bytes[0] != CH_CR || ovf_next) begin
      res.status = ST_BAD_END;
    end else if (!star_seen || rx_sum != running_xor) begin
      res.status = ST_BAD_SUM;
    end else begin
      res.status = ST_OK;
    end
  end

  assign res_valid = active && is_lf;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_sentence     <= 1'b0;
      byte_position   <= 8'd0;
      running_xor     <= 8'd0;
      star_seen       <= 1'b0;
      second_is_g     <= 1'b0;
      field_counter   <= 8'd0;
      overflowed      <= 1'b0;
      recent_bytes[0] <= 8'd0;
      recent_bytes[1] <= 8'd0;
      recent_bytes[2] <= 8'd0;
    end else if (byte_valid && is_dollar) begin
      in_sentence     <= 1'b1;
      byte_position   <= 8'd1;
      running_xor     <= 8'd0;
      star_seen       <= 1'b0;
      second_is_g     <= 1'b0;
      field_counter   <= 8'd1;
      overflowed      <= 1'b0;
      recent_bytes[0] <= 8'd0;
      recent_bytes[1] <= 8'd0;
      recent_bytes[2] <= 8'd0;
    end else if (active) begin
      byte_position <= pos_next;
      overflowed    <= ovf_next;
      if (is_lf) begin
        in_sentence <= 1'b0;
      end else begin
        if (byte_position == 8'd1) begin
          second_is_g <= (data_byte == CH_G);
        end
        if (!star_seen) begin
          if (data_byte == CH_STAR) begin
            star_seen <= 1'b1;
          end else begin
            running_xor <= running_xor ^ data_byte;
            if (data_byte == CH_COMMA && field_counter < MaxLen) begin
              field_counter <= field_counter + 8'd1;
            end
          end
        end
        recent_bytes[2] <= recent_bytes[1];
        recent_bytes[1] <= recent_bytes[0];
        recent_bytes[0] <= data_byte;
      end
    end
  end

endmodule

// ----- design/nsc_out_buf.sv -----
// ----------------------------------------------------------------------------
// NMEA sentence checker output buffer
// Result register plus skid entry so the input side keeps flowing on a stall.
// ----------------------------------------------------------------------------
module nsc_out_buf import nsc_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    res_valid,
  input  result_t res,
  output logic    in_ready,
  output logic    out_valid,
  output result_t out_res,
  input  logic    out_ready
);

  logic    skid_valid;
  result_t skid_res;
  logic    out_free;

  assign in_ready = !skid_valid;
  assign out_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (out_free) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end
    end else if (out_free) begin
      out_valid <= res_valid;
    end else if (res_valid) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (out_free) begin
        out_res <= skid_res;
      end
    end else if (out_free) begin
      out_res <= res;
    end else if (res_valid) begin
      skid_res <= res;
    end
  end

endmodule

// ----- design/nmea_sentence_checker_top.sv -----
// ----------------------------------------------------------------------------
// NMEA sentence checker
// Checks NMEA 0183 sentences byte by byte and reports one status per sentence.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries one received character per transaction (tdata[7:0]).
//   '$' opens a sentence (a second '$' restarts it); bytes outside a sentence
//   are dropped. On LF inside a sentence one result goes out on m_axis.
//   m_axis tdata, from bit 0: status[1:0], computed_sum[9:2],
//   received_sum[17:10], field_total[25:18], sentence_length[33:26],
//   zero padding up to bit 39.
//   Throughput: one character per cycle while s_axis_tready is high.
//   The result of an accepted LF is registered in the output register if it is free.
//   A stalled result sits in the output register; a second result lands in
//   the skid entry, and only then does s_axis_tready drop until the receiver
//   drains it.
//   Reset (rst, synchronous) closes any open sentence and empties the output.
// ----------------------------------------------------------------------------
`include "nmea_sentence_checker_top_defines.svh"

module nmea_sentence_checker_top import nsc_pkg::*; #(
  parameter int MAX_SENTENCE = MaxSentenceDefault
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [7:0]            s_axis_tdata,   // data_byte[7:0]
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // status, computed_sum, received_sum, field_total, sentence_length, pad
  output logic [TdataWidth-1:0] m_axis_tdata
);

  logic    byte_valid;
  logic    res_valid;
  result_t res;
  result_t out_res;

  assign byte_valid = s_axis_tvalid && s_axis_tready;

  nsc_tracker #(
    .MAX_SENTENCE(MAX_SENTENCE)
  ) u_tracker (
    .clk       (clk),
    .rst       (rst),
    .byte_valid(byte_valid),
    .data_byte (s_axis_tdata),
    .res_valid (res_valid),
    .res       (res)
  );

  nsc_out_buf u_out_buf (
    .clk      (clk),
    .rst      (rst),
    .res_valid(res_valid),
    .res      (res),
    .in_ready (s_axis_tready),
    .out_valid(m_axis_tvalid),
    .out_res  (out_res),
    .out_ready(m_axis_tready)
  );

  assign m_axis_tdata = {{(TdataWidth-ResultWidth){1'b0}}, out_res};

  `NSC_ASSERT_IMP(a_stall_only_when_full, !s_axis_tready, m_axis_tvalid)
  `NSC_ASSERT_NEXT(a_result_reaches_output, res_valid, m_axis_tvalid)
  `NSC_ASSERT_IMP(a_result_from_lf, res_valid, byte_valid && s_axis_tdata == CH_LF)
  `NSC_ASSERT_IMP(a_length_limit, m_axis_tvalid,
    out_res.sentence_length <= 8'(MAX_SENTENCE) && out_res.field_total <= 8'(MAX_SENTENCE))

endmodule

// ----- verif/nmea_sentence_checker_top_tb.sv -----
// ----------------------------------------------------------------------------
// NMEA sentence checker testbench
// Streams characters into the checker and holds its own copy of the sentence
// state to predict every status result. Each result leaving the block is
// checked field by field. Valid and ready toggle at random, but not in the last
// phase; the byte stream mixes good sentences, broken ones and noise.
// ----------------------------------------------------------------------------
module nmea_sentence_checker_top_tb;
  import nsc_pkg::*;

  localparam logic [7:0] MaxLen     = 8'(MaxSentenceDefault);
  localparam int         CycleLimit = 400000;
  localparam int         PhaseChars = 560;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [7:0]            s_axis_tdata = 8'h00;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [TdataWidth-1:0] m_axis_tdata;

  // characters waiting to go out, and sentence results waiting to come back
  logic [7:0] uart_chars[$];
  result_t    sentence_verdicts[$];

  int chars_queued   = 0;
  int chars_taken    = 0;
  int errors         = 0;
  int cycles         = 0;
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  bit s_fire         = 1'b0;

  // predicted sentence state
  logic       in_sent     = 1'b0;
  logic [7:0] sent_pos    = 8'h00;
  logic [7:0] sent_xor    = 8'h00;
  logic [7:0] sent_fields = 8'h00;
  logic       star_hit    = 1'b0;
  logic       g_second    = 1'b0;
  logic       too_long    = 1'b0;
  logic [7:0] tail [3]    = '{default: 8'h00};  // [0] newest

  nmea_sentence_checker_top i_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always #4 clk = ~clk;

  task automatic report_error(input string what);
    errors++;
    if (errors <= 100) begin
      $display("ERROR cycle %0d: %s", cycles, what);
    end
  endtask

  function automatic logic [3:0] digit_val(input logic [7:0] c);
    if (c >= "0" && c <= "9") return 4'(c - "0");
    if (c >= "A" && c <= "F") return 4'(c - "A" + 8'd10);
    if (c >= "a" && c <= "f") return 4'(c - "a" + 8'd10);
    return 4'd0;
  endfunction

  // advances the sentence state by one character; returns 1 when a result is due
  function automatic bit judge_char(input logic [7:0] c, output result_t verdict);
    logic       at_second;
    logic [7:0] rx_sum;
    verdict = '0;
    if (c == CH_DOLLAR) begin
      in_sent     = 1'b1;
      sent_pos    = 8'd1;
      sent_xor    = 8'h00;
      sent_fields = 8'd1;
      star_hit    = 1'b0;
      g_second    = 1'b0;
      too_long    = 1'b0;
      tail        = '{default: 8'h00};
      return 1'b0;
    end
    if (!in_sent) return 1'b0;
    at_second = (sent_pos == 8'd1);
    if (sent_pos < MaxLen) sent_pos++;
    else too_long = 1'b1;
    if (c == CH_LF) begin
      rx_sum = {digit_val(tail[2]), digit_val(tail[1])};
      if (!g_second) verdict.status = ST_BAD_START;
      else if (tail[0] != CH_CR || too_long) verdict.status = ST_BAD_END;
      else if (!star_hit || rx_sum != sent_xor) verdict.status = ST_BAD_SUM;
      else verdict.status = ST_OK;
      verdict.computed_sum    = sent_xor;
      verdict.received_sum    = rx_sum;
      verdict.field_total     = sent_fields;
      verdict.sentence_length = sent_pos;
      in_sent = 1'b0;
      return 1'b1;
    end
    if (at_second) g_second = (c == CH_G);
    if (!star_hit) begin
      if (c == CH_STAR) begin
        star_hit = 1'b1;
      end else begin
        sent_xor ^= c;
        if (c == CH_COMMA && sent_fields < MaxLen) sent_fields++;
      end
    end
    tail[2] = tail[1];
    tail[1] = tail[0];
    tail[0] = c;
    return 1'b0;
  endfunction

  task automatic check_field(input string name, input logic [7:0] got, input logic [7:0] want);
    if (got !== want) begin
      report_error($sformatf("%s: got 0x%02h, expected 0x%02h", name, got, want));
    end
  endtask

  task automatic push_char(input logic [7:0] c);
    uart_chars.push_back(c);
    chars_queued++;
  endtask

  task automatic push_text(input string s);
    for (int i = 0; i < s.len(); i++) push_char(s[i]);
  endtask

  function automatic logic [7:0] hex_char(input logic [3:0] n, input bit upper);
    if (n < 4'd10) return 8'("0") + 8'(n);
    return (upper ? 8'("A") : 8'("a")) + 8'(n) - 8'd10;
  endfunction

  // mostly well-formed sentences with random content, some broken, some noise
  task automatic queue_random(input int budget);
    int         start, body_len, r, n;
    logic [7:0] c, sum, sum_sent;
    bit         upper;
    start = chars_queued;
    while (chars_queued - start < budget) begin
      r = $urandom_range(99);
      if (r < 8) begin
        n = $urandom_range(1, 6);
        repeat (n) push_char(8'($urandom_range(255)));
      end else begin
        push_char(CH_DOLLAR);
        c = ($urandom_range(99) < 8) ? 8'($urandom_range(8'h20, 8'h7E)) : CH_G;
        push_char(c);
        sum = c;
        body_len = ($urandom_range(99) < 3) ? $urandom_range(100, 150) : $urandom_range(0, 20);
        repeat (body_len) begin
          r = $urandom_range(99);
          if (r < 20) c = CH_COMMA;
          else if (r < 24) c = 8'($urandom_range(255));
          else c = 8'($urandom_range(8'h20, 8'h7E));
          if (c == CH_DOLLAR || c == CH_STAR || c == CH_LF) c = "A";
          push_char(c);
          sum ^= c;
        end
        r = $urandom_range(99);
        if (r < 5) begin
          // abandoned: the next '$' restarts
        end else if (r < 11) begin
          push_char(CH_CR);
          push_char(CH_LF);
        end else begin
          push_char(CH_STAR);
          // junk after the first star, later stars included
          if ($urandom_range(99) < 10) begin
            n = $urandom_range(1, 3);
            repeat (n) begin
              r = $urandom_range(99);
              if (r < 40) c = CH_STAR;
              else if (r < 70) c = CH_COMMA;
              else c = 8'($urandom_range(8'h41, 8'h5A));
              push_char(c);
            end
          end
          sum_sent = ($urandom_range(99) < 8) ? 8'($urandom_range(255)) : sum;
          upper = 1'($urandom_range(1));
          push_char(hex_char(sum_sent[7:4], upper));
          if ($urandom_range(99) < 4) push_char("g");
          else push_char(hex_char(sum_sent[3:0], upper));
          if ($urandom_range(99) >= 6) push_char(CH_CR);
          push_char(CH_LF);
        end
      end
    end
  endtask

  task automatic wait_drained();
    do @(negedge clk);
    while (chars_taken != chars_queued || sentence_verdicts.size() != 0);
  endtask

  // driver
  always @(negedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
      m_axis_tready <= 1'b0;
    end else begin
      if (!s_axis_tvalid || s_fire) begin
        if (uart_chars.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          s_axis_tdata  <= uart_chars.pop_front();
          s_axis_tvalid <= 1'b1;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
      m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // monitor
  always @(posedge clk) begin : monitor
    result_t got, want, made;
    cycles++;
    if (cycles > CycleLimit) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
    s_fire = !rst && s_axis_tvalid && s_axis_tready;
    if (s_fire) begin
      chars_taken++;
      if (judge_char(s_axis_tdata, made)) sentence_verdicts.push_back(made);
    end
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got = m_axis_tdata[ResultWidth-1:0];
      if (sentence_verdicts.size() == 0) begin
        report_error($sformatf("unexpected result 0x%010h", m_axis_tdata));
      end else begin
        want = sentence_verdicts.pop_front();
        check_field("status", 8'(got.status), 8'(want.status));
        check_field("computed_sum", got.computed_sum, want.computed_sum);
        check_field("received_sum", got.received_sum, want.received_sum);
        check_field("field_total", got.field_total, want.field_total);
        check_field("sentence_length", got.sentence_length, want.sentence_length);
        check_field("padding", 8'(m_axis_tdata[TdataWidth-1:ResultWidth]), 8'h00);
      end
    end
  end

  initial begin
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    send_idle_pct  = 7;
    recv_stall_pct = 87;
    // directed: noise outside a sentence, good sentence, early end,
    // restart with bad end, missing star
    push_char(8'h00);
    push_char(8'hFF);
    push_char(CH_LF);
    push_text("$G,*6b");
    push_char(CH_CR);
    push_char(CH_LF);
    push_text("$");
    push_char(CH_LF);
    push_text("$$Gx");
    push_char(CH_LF);
    push_text("$G");
    push_char(CH_CR);
    push_char(CH_LF);
    // sender holds off until every result is back
    wait_drained();

    queue_random(PhaseChars);
    wait_drained();

    send_idle_pct  = 87;
    recv_stall_pct = 7;
    queue_random(PhaseChars);
    wait_drained();

    send_idle_pct  = 0;
    recv_stall_pct = 0;
    queue_random(PhaseChars);
    wait_drained();

    repeat (16) @(posedge clk);
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
